FILE: hdl/delimited_frame_search_defines.svh
// Assertion macros used by the checker file of the frame search block.
// Depends on nothing; the macros expect signals named clock and, but for the raw one, reset in scope.
`ifndef DELIMITED_FRAME_SEARCH_DEFINES_SVH
`define DELIMITED_FRAME_SEARCH_DEFINES_SVH

// Implication in the same cycle, disabled while reset is high.
`define DFS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame search assertion failed");

// Implication into the next cycle, disabled while reset is high.
`define DFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame search assertion failed");

// Next-cycle implication that stays active during reset.
`define DFS_ASSERT_NEXT_RAW(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("frame search assertion failed");

`endif

FILE: hdl/dfs_pkg.sv
// Package for the delimited frame search: field widths, register indexes
// and the one-hot search phase type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

   localparam int BYTE_W      = 8;
   localparam int PATTERN_W   = 64;
   localparam int LEN_W       = 4;
   localparam int START_W     = 10;
   localparam int LENGTH_W    = 11;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_PATTERN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_PATTERN = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_LENGTH  = 2'd3;

   typedef enum logic [2:0] {
      PHASE_HEAD = 3'b001,
      PHASE_TAIL = 3'b010,
      PHASE_DONE = 3'b100
   } phase_type;

endpackage

`default_nettype wire

FILE: hdl/dfs_matcher.sv
// Window compare: tests whether the newest bytes of the history equal the
// low bytes of a pattern. Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfs_matcher #(
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic [dfs_pkg::PATTERN_W-1:0]              pattern,
   input  logic [dfs_pkg::LEN_W-1:0]                  pat_len,
   input  logic [dfs_pkg::BYTE_W*MAX_PATTERN_BYTES-1:0] history,
   output logic                                       hit
);
   import dfs_pkg::*;

   // History byte at age a (0 is newest) lines up with pattern byte j when
   // a + j + 1 equals the pattern length; the oldest byte meets pattern byte 0.
   always_comb begin
      hit = 1'b1;
      for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
         for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            if ((a + j + 1) == int'(pat_len)) begin
               if (history[a*BYTE_W +: BYTE_W] != pattern[j*BYTE_W +: BYTE_W]) begin
                  hit = 1'b0;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/delimited_frame_search.sv
// Top level of the delimited frame search: input register, search state,
// result register and configuration registers. Depends on dfs_pkg, dfs_matcher.
//
//   channel  direction  payload
//   req_     in         tdata = rx_byte, tlast = frame_end
//   rsp_     out        tdata = span_start, span_length; tuser = span_found
//   csr_     in         write enable, register index, write data
//
// An item is taken every cycle unless a last item waits on a stalled
// result, while non-last items keep flowing; a frame's last item writes its
// result into the output register, which holds a stalled result, as the
// item leaves the input register. The search state update (masked window
// compares and position counters) sets the one-item-per-cycle figure. Reset
// is synchronous and clears all control state and sets the lengths to one.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_search #(
   parameter int FRAME_DEPTH       = 1024,
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dfs_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] rx_byte
   input  logic                             req_tlast,   // frame_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [9:0] span_start, [20:10] span_length
   output logic                             rsp_tuser,   // [0] span_found
   input  logic                             csr_wr_en,
   input  logic [dfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dfs_pkg::PATTERN_W-1:0]    csr_wdata
);
   import dfs_pkg::*;

   localparam int POS_W  = $clog2(FRAME_DEPTH + 1);
   localparam int HIST_W = BYTE_W * MAX_PATTERN_BYTES;

   logic [PATTERN_W-1:0] head_pattern_ff, head_pattern_in;
   logic [LEN_W-1:0]     head_length_ff, head_length_in;
   logic [PATTERN_W-1:0] tail_pattern_ff, tail_pattern_in;
   logic [LEN_W-1:0]     tail_length_ff, tail_length_in;

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]    in_byte_ff, in_byte_in;
   logic                 in_last_ff, in_last_in;

   logic [HIST_W-1:0]    hist_ff, hist_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     head_start_ff, head_start_in;
   logic [POS_W-1:0]     after_head_ff, after_head_in;
   logic [POS_W-1:0]     found_len_ff, found_len_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [LENGTH_W-1:0]  rsp_length_ff, rsp_length_in;

   logic                 stage_go;
   logic                 in_range;
   logic [POS_W-1:0]     pos_next;
   logic [POS_W-1:0]     after_next;
   logic [LEN_W-1:0]     head_len_c;
   logic [LEN_W-1:0]     tail_len_c;
   logic [HIST_W-1:0]    hist_shift;
   logic                 head_hit;
   logic                 tail_hit;
   phase_type            phase_upd;
   logic [POS_W-1:0]     head_start_upd;
   logic [POS_W-1:0]     found_len_upd;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      priority if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > LEN_W'(MAX_PATTERN_BYTES)) begin
         r = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // A non-last item never needs the output register, so it always moves on.
   assign stage_go   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;

   assign in_range   = pos_ff < POS_W'(FRAME_DEPTH);
   assign pos_next   = pos_ff + 1'b1;
   assign after_next = after_head_ff + 1'b1;
   assign head_len_c = clamp_len(head_length_ff);
   assign tail_len_c = clamp_len(tail_length_ff);
   // Newest byte enters at age zero; the oldest falls off the top.
   assign hist_shift = HIST_W'({hist_ff, in_byte_ff});

   dfs_matcher #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_head_match (
      .pattern (head_pattern_ff),
      .pat_len (head_len_c),
      .history (hist_shift),
      .hit     (head_hit)
   );

   dfs_matcher #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_tail_match (
      .pattern (tail_pattern_ff),
      .pat_len (tail_len_c),
      .history (hist_shift),
      .hit     (tail_hit)
   );

   always_comb begin
      head_pattern_in = head_pattern_ff;
      head_length_in  = head_length_ff;
      tail_pattern_in = tail_pattern_ff;
      tail_length_in  = tail_length_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEAD_PATTERN: head_pattern_in = csr_wdata;
            CSR_HEAD_LENGTH:  head_length_in  = csr_wdata[LEN_W-1:0];
            CSR_TAIL_PATTERN: tail_pattern_in = csr_wdata;
            CSR_TAIL_LENGTH:  tail_length_in  = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   // Search update for the item in the input register.
   always_comb begin
      hist_in        = hist_ff;
      pos_in         = pos_ff;
      after_head_in  = after_head_ff;
      phase_upd      = phase_ff;
      head_start_upd = head_start_ff;
      found_len_upd  = found_len_ff;
      if (in_range) begin
         hist_in = hist_shift;
         pos_in  = pos_next;
         unique case (phase_ff)
            PHASE_HEAD: begin
               if ((pos_next >= POS_W'(head_len_c)) && head_hit) begin
                  head_start_upd = pos_next - POS_W'(head_len_c);
                  after_head_in  = '0;
                  phase_upd      = PHASE_TAIL;
               end
            end
            PHASE_TAIL: begin
               after_head_in = after_next;
               if ((after_next >= POS_W'(tail_len_c)) && tail_hit) begin
                  found_len_upd = pos_next - head_start_ff;
                  phase_upd     = PHASE_DONE;
               end
            end
            PHASE_DONE: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      head_start_in = head_start_ff;
      found_len_in  = found_len_ff;
      if (stage_go) begin
         phase_in      = phase_upd;
         head_start_in = head_start_upd;
         found_len_in  = found_len_upd;
         if (in_last_ff) begin
            phase_in = PHASE_HEAD;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_length_in = rsp_length_ff;
      if (stage_go && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = (phase_upd == PHASE_DONE);
         if (phase_upd == PHASE_DONE) begin
            rsp_start_in  = START_W'({{START_W{1'b0}}, head_start_upd});
            rsp_length_in = LENGTH_W'({{LENGTH_W{1'b0}}, found_len_upd});
         end else begin
            rsp_start_in  = '0;
            rsp_length_in = '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_pattern_ff <= '0;
         head_length_ff  <= LEN_W'(1);
         tail_pattern_ff <= '0;
         tail_length_ff  <= LEN_W'(1);
         in_valid_ff     <= 1'b0;
         pos_ff          <= '0;
         phase_ff        <= PHASE_HEAD;
         rsp_valid_ff    <= 1'b0;
      end else begin
         head_pattern_ff <= head_pattern_in;
         head_length_ff  <= head_length_in;
         tail_pattern_ff <= tail_pattern_in;
         tail_length_ff  <= tail_length_in;
         in_valid_ff     <= in_valid_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (stage_go) begin
            pos_ff <= in_last_ff ? '0 : pos_in;
         end
      end
   end

   // The history needs no clearing: compares only look at bytes of the
   // current frame, guarded by the position and after-head counts.
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_last_ff    <= in_last_in;
      head_start_ff <= head_start_in;
      found_len_ff  <= found_len_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_length_ff <= rsp_length_in;
      if (stage_go) begin
         hist_ff       <= hist_in;
         after_head_ff <= after_head_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_length_ff, rsp_start_ff});

endmodule

`default_nettype wire

FILE: hdl/dfs_checker.sv
// Port-level checker for the delimited frame search, bound to the top level.
// Depends on dfs_pkg and delimited_frame_search_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "delimited_frame_search_defines.svh"

module dfs_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [dfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                             rsp_tuser
);
   import dfs_pkg::*;

   // A waiting result keeps its value until it is taken.
   `DFS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // A frame without a span reports zero start and zero length.
   `DFS_ASSERT_IMPLY(a_empty_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   // With the output register empty the input side is never stalled.
   `DFS_ASSERT_IMPLY(a_ready_when_empty, !rsp_tvalid, req_tready)

   // Reset leaves no result pending.
   `DFS_ASSERT_NEXT_RAW(a_reset_clears, reset, !rsp_tvalid)

endmodule

bind delimited_frame_search dfs_checker u_dfs_checker (.*);

`default_nettype wire
